@@ hw/rtl/car_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_pkg
// Shared types, constants, delay-line tables and saturation helpers for the
// comb/allpass reverb.
// ----------------------------------------------------------------------------
package car_pkg;

    localparam int SW     = 16;        // sample width, Q1.15
    localparam int IW     = 24;        // internal width, Q4.20
    localparam int CW     = 18;        // signed coefficient operand
    localparam int MA_W   = IW + 1;    // multiplier data operand
    localparam int PROD_W = MA_W + CW;
    localparam int ACC_W  = 44;

    localparam int COMB_TOTAL = 11024;
    localparam int AP_TOTAL   = 1563;
    localparam int CA_W       = 14;
    localparam int AA_W       = 11;
    localparam int CP_W       = 11;
    localparam int AP_W       = 10;

    localparam logic [1:0] REG_INPUT_GAIN = 2'd0;
    localparam logic [1:0] REG_FEEDBACK   = 2'd1;
    localparam logic [1:0] REG_DAMPING    = 2'd2;
    localparam logic [1:0] REG_WET        = 2'd3;

    localparam logic signed [ACC_W-1:0] IMAX = ACC_W'((64'sd1 <<< (IW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] IMIN = -IMAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SMAX = ACC_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SMIN = -SMAX - ACC_W'(1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_X1,
        ST_X2,
        ST_CRD,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_C4,
        ST_C5,
        ST_ARD,
        ST_A1,
        ST_M1,
        ST_M2,
        ST_M3
    } car_state_t;

    function automatic logic [CP_W-1:0] comb_len(input logic [2:0] i);
        case (i)
            3'd0:    return CP_W'(1116);
            3'd1:    return CP_W'(1188);
            3'd2:    return CP_W'(1277);
            3'd3:    return CP_W'(1356);
            3'd4:    return CP_W'(1422);
            3'd5:    return CP_W'(1491);
            3'd6:    return CP_W'(1557);
            default: return CP_W'(1617);
        endcase
    endfunction

    function automatic logic [CA_W-1:0] comb_base(input logic [2:0] i);
        case (i)
            3'd0:    return CA_W'(0);
            3'd1:    return CA_W'(1116);
            3'd2:    return CA_W'(2304);
            3'd3:    return CA_W'(3581);
            3'd4:    return CA_W'(4937);
            3'd5:    return CA_W'(6359);
            3'd6:    return CA_W'(7850);
            default: return CA_W'(9407);
        endcase
    endfunction

    function automatic logic [AP_W-1:0] ap_len(input logic [1:0] i);
        case (i)
            2'd0:    return AP_W'(556);
            2'd1:    return AP_W'(441);
            2'd2:    return AP_W'(341);
            default: return AP_W'(225);
        endcase
    endfunction

    function automatic logic [AA_W-1:0] ap_base(input logic [1:0] i);
        case (i)
            2'd0:    return AA_W'(0);
            2'd1:    return AA_W'(556);
            2'd2:    return AA_W'(997);
            default: return AA_W'(1338);
        endcase
    endfunction

    function automatic logic signed [IW-1:0] sat_int(input logic signed [ACC_W-1:0] v);
        if (v > IMAX)
            return IMAX[IW-1:0];
        else if (v < IMIN)
            return IMIN[IW-1:0];
        else
            return v[IW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] sat_smp(input logic signed [ACC_W-1:0] v);
        if (v > SMAX)
            return SMAX[SW-1:0];
        else if (v < SMIN)
            return SMIN[SW-1:0];
        else
            return v[SW-1:0];
    endfunction

endpackage

@@ hw/rtl/car_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module car_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/comb_allpass_reverb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comb_allpass_reverb
// Mono reverb: input gain, parallel damped comb filters, series allpass
// stages and a dry/wet mix, computed on one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_t* stream: one beat carries a Q1.15 sample in
//   s_tdata and the end-of-block mark in s_tlast. Each input beat yields
//   exactly one output beat on m_t*, with the mixed sample in m_tdata and
//   s_tlast copied to m_tlast.
//   Gains are written on the cfg_* channel (index 0 input gain, 1 comb
//   feedback, 2 damping, 3 wet share); cfg_ready is always high. Write them
//   only while no sample is in flight.
//   Timing: a small sequencer steps one sample through the 25x18 multiplier:
//   the input gain (product, then scaling), each comb (read, three products,
//   write), each allpass (read, then write back) and the mix. When the output
//   is free the result is registered at the same edge at which s_tready
//   rises, and a new beat is taken only once the previous sample is through.
//   The multiplier and the single read port of each delay memory set the
//   pace.
//   s_tready stays low while a sample is being processed.
//   Reset: after rst_n rises the block clears both delay memories, one
//   address a cycle, before it takes the first sample.
//   Configuration writes are taken during that pass.
//   Stall: the result sits in the output register until m_tready; the next
//   sample is accepted meanwhile and only its last step waits for the slot.
// ----------------------------------------------------------------------------
module comb_allpass_reverb #(
    parameter int COMB_COUNT    = 8,
    parameter int ALLPASS_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [car_pkg::SW-1:0] s_tdata,   // [15:0] sample_in
    input  logic        s_tlast,              // block_end
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [car_pkg::SW-1:0] m_tdata,   // [15:0] sample_out
    output logic        m_tlast               // block_end_out
);

    import car_pkg::*;

    localparam int CI_W = (COMB_COUNT > 1) ? $clog2(COMB_COUNT) : 1;
    localparam int AI_W = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
    localparam logic [CI_W-1:0] C_LAST = CI_W'(COMB_COUNT - 1);
    localparam logic [AI_W-1:0] A_LAST = AI_W'(ALLPASS_COUNT - 1);
    localparam int SUM_W = IW + 3;

    // configuration registers
    logic [15:0] gain_reg;
    logic [15:0] fb_reg;
    logic [16:0] damp_reg;
    logic [16:0] wet_amt_reg;

    car_state_t state_reg, state_next;

    logic [CA_W-1:0] clr_reg;
    logic [CI_W-1:0] c_reg;
    logic [AI_W-1:0] a_reg;
    logic [CP_W-1:0] cpos_reg [COMB_COUNT];
    logic [AP_W-1:0] apos_reg [ALLPASS_COUNT];
    logic signed [IW-1:0] lp_reg [COMB_COUNT];

    logic signed [SW-1:0]     smp_reg;
    logic                     last_reg;
    logic signed [IW-1:0]     x_reg;
    logic signed [IW-1:0]     y_reg;
    logic signed [IW-1:0]     f_reg;
    logic signed [IW-1:0]     wet_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic                     out_valid_reg;
    logic signed [SW-1:0]     out_data_reg;
    logic                     out_last_reg;

    // clamped coefficients
    logic [15:0] g_cl;
    logic [15:0] fb_cl;
    logic [16:0] d_cl;
    logic [16:0] w_cl;
    logic [16:0] one_m_d;
    logic [16:0] one_m_w;

    // shared multiplier
    logic signed [MA_W-1:0]   mul_a;
    logic signed [CW-1:0]     mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  prod_sh;

    // memories
    logic                  cm_we, am_we;
    logic [CA_W-1:0]       cm_waddr, cm_raddr, cslot;
    logic [AA_W-1:0]       am_waddr, am_raddr, aslot;
    logic [IW-1:0]         cm_wdata, am_wdata, cm_rdata, am_rdata;

    logic signed [IW-1:0]    b_val;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [IW-1:0]    f_val;
    logic signed [IW-1:0]    mix_val;
    logic                    in_beat, out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tlast   = out_last_reg;

    assign g_cl    = (gain_reg > 16'd32768) ? 16'd32768 : gain_reg;
    assign fb_cl   = (fb_reg < 16'd3277) ? 16'd3277 : ((fb_reg > 16'd62259) ? 16'd62259 : fb_reg);
    assign d_cl    = (damp_reg > 17'd65536) ? 17'd65536 : damp_reg;
    assign w_cl    = (wet_amt_reg > 17'd65536) ? 17'd65536 : wet_amt_reg;
    assign one_m_d = 17'd65536 - d_cl;
    assign one_m_w = 17'd65536 - w_cl;

    assign prod_next = mul_a * mul_b;
    assign prod_sh   = ACC_W'(prod_reg >>> 16);

    assign cslot = comb_base(3'(c_reg)) + CA_W'(cpos_reg[c_reg]);
    assign aslot = ap_base(2'(a_reg)) + AA_W'(apos_reg[a_reg]);

    assign b_val    = $signed(am_rdata);
    assign sum_next = sum_reg + SUM_W'(y_reg);
    assign f_val    = sat_int(acc_reg + prod_sh);
    assign mix_val  = sat_int(acc_reg + prod_sh);

    car_ram #(.WIDTH(IW), .DEPTH(COMB_TOTAL)) u_comb_ram (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (cm_wdata),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

    car_ram #(.WIDTH(IW), .DEPTH(AP_TOTAL)) u_ap_ram (
        .clk   (clk),
        .we    (am_we),
        .waddr (am_waddr),
        .wdata (am_wdata),
        .raddr (am_raddr),
        .rdata (am_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == CA_W'(COMB_TOTAL - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_beat) state_next = ST_X1;
            ST_X1:    state_next = ST_X2;
            ST_X2:    state_next = ST_CRD;
            ST_CRD:   state_next = ST_C1;
            ST_C1:    state_next = ST_C2;
            ST_C2:    state_next = ST_C3;
            ST_C3:    state_next = ST_C4;
            ST_C4:    state_next = ST_C5;
            ST_C5:    state_next = (c_reg == C_LAST) ? ST_ARD : ST_CRD;
            ST_ARD:   state_next = ST_A1;
            ST_A1:    state_next = (a_reg == A_LAST) ? ST_M1 : ST_ARD;
            ST_M1:    state_next = ST_M2;
            ST_M2:    state_next = ST_M3;
            ST_M3:    if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath controls: multiplier operands and memory ports
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        cm_we    = 1'b0;
        cm_waddr = cslot;
        cm_wdata = IW'(sat_int(ACC_W'(x_reg) + prod_sh));
        cm_raddr = cslot;
        am_we    = 1'b0;
        am_waddr = aslot;
        am_wdata = IW'(sat_int(ACC_W'(wet_reg) + ACC_W'(b_val >>> 1)));
        am_raddr = aslot;
        case (state_reg)
            ST_CLEAR:
            begin
                cm_we    = 1'b1;
                cm_waddr = clr_reg;
                cm_wdata = '0;
                am_we    = (clr_reg < CA_W'(AP_TOTAL));
                am_waddr = clr_reg[AA_W-1:0];
                am_wdata = '0;
            end
            ST_X1:
            begin
                mul_a = MA_W'(smp_reg);
                mul_b = CW'(g_cl);
            end
            ST_C1:
            begin
                mul_a = MA_W'(lp_reg[c_reg]);
                mul_b = CW'(d_cl);
            end
            ST_C2:
            begin
                mul_a = MA_W'(y_reg);
                mul_b = CW'(one_m_d);
            end
            ST_C4:
            begin
                mul_a = MA_W'(f_reg);
                mul_b = CW'(fb_cl);
            end
            ST_C5:   cm_we = 1'b1;
            ST_A1:   am_we = 1'b1;
            ST_M1:
            begin
                mul_a = MA_W'(x_reg);
                mul_b = CW'(one_m_w);
            end
            ST_M2:
            begin
                mul_a = MA_W'(wet_reg);
                mul_b = CW'(w_cl);
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            c_reg         <= '0;
            a_reg         <= '0;
            out_valid_reg <= 1'b0;
            gain_reg      <= 16'd8192;
            fb_reg        <= 16'd55050;
            damp_reg      <= 17'd13107;
            wet_amt_reg   <= 17'd21627;
            for (int i = 0; i < COMB_COUNT; i++)
            begin
                cpos_reg[i] <= '0;
                lp_reg[i]   <= '0;
            end
            for (int i = 0; i < ALLPASS_COUNT; i++)
            begin
                apos_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_INPUT_GAIN: gain_reg    <= cfg_data[15:0];
                    REG_FEEDBACK:   fb_reg      <= cfg_data[15:0];
                    REG_DAMPING:    damp_reg    <= cfg_data;
                    REG_WET:        wet_amt_reg <= cfg_data;
                    default: ;
                endcase
            end
            // load a new result, else drop the one just taken
            if ((state_reg == ST_M3) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR: clr_reg <= clr_reg + CA_W'(1);
                ST_IDLE:
                begin
                    c_reg <= '0;
                    a_reg <= '0;
                end
                ST_C3:    lp_reg[c_reg] <= f_val;
                ST_C5:
                begin
                    cpos_reg[c_reg] <= (cpos_reg[c_reg] == comb_len(3'(c_reg)) - CP_W'(1))
                                       ? '0 : cpos_reg[c_reg] + CP_W'(1);
                    c_reg <= c_reg + CI_W'(1);
                end
                ST_A1:
                begin
                    apos_reg[a_reg] <= (apos_reg[a_reg] == ap_len(2'(a_reg)) - AP_W'(1))
                                       ? '0 : apos_reg[a_reg] + AP_W'(1);
                    a_reg <= a_reg + AI_W'(1);
                end
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                smp_reg  <= $signed(s_tdata);
                last_reg <= s_tlast;
                sum_reg  <= '0;
            end
            ST_X1:  prod_reg <= prod_next;
            ST_X2:  x_reg <= sat_int(ACC_W'(prod_reg >>> 8));
            ST_C1:
            begin
                y_reg    <= $signed(cm_rdata);
                prod_reg <= prod_next;
            end
            ST_C2:
            begin
                acc_reg  <= prod_sh;
                prod_reg <= prod_next;
            end
            ST_C3:  f_reg <= f_val;
            ST_C4:  prod_reg <= prod_next;
            ST_C5:
            begin
                sum_reg <= sum_next;
                wet_reg <= sat_int(ACC_W'(sum_next >>> 3));
            end
            ST_A1:  wet_reg <= sat_int(ACC_W'(b_val) - ACC_W'(wet_reg));
            ST_M1:  prod_reg <= prod_next;
            ST_M2:
            begin
                acc_reg  <= prod_sh;
                prod_reg <= prod_next;
            end
            ST_M3:
            begin
                if (out_free)
                begin
                    out_data_reg <= sat_smp(ACC_W'(mix_val >>> (IW - 4 - (SW - 1))));
                    out_last_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ hw/rtl/car_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// car_chk
// Port-level checks for comb_allpass_reverb, bound to the top level.
// ----------------------------------------------------------------------------
module car_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // ready drops after each accepted beat while that sample is worked on
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready after accepted beat");

    // a new result only comes out of a sample in flight
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared with no sample in flight");

    // hold a stalled output beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output beat changed");

endmodule

bind comb_allpass_reverb car_chk u_car_chk (.*);
